// ----- design/rpg_pkg.sv -----
`default_nettype none

package rpg_pkg;

    // Channel width and the full-scale value of one channel.
    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned IN_W     = 8;
    localparam int unsigned OUT_W    = 3 * CHAN_W;
    localparam int unsigned IDX_W    = 2;
    localparam logic [CHAN_W-1:0] FULL_SCALE = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [IDX_W-1:0] REG_FADE_STEP   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROTATE_MODE = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] r;
    } color_t;

    typedef struct packed {
        logic [CHAN_W-1:0] fade_step;
        logic [CHAN_W-1:0] brightness;
        logic              rotate_mode;
    } cfg_t;

    localparam color_t PURE_RED = '{b: 8'd0, g: 8'd0, r: FULL_SCALE};

    // One fade step along the color wheel. A borrow out of the 8-bit
    // subtraction hands the remainder over to the next channel pair.
    function automatic color_t fade_once(color_t c_in, logic [CHAN_W-1:0] step);
        color_t            c;
        logic [CHAN_W-1:0] s;
        logic [CHAN_W:0]   d;
        logic [CHAN_W-1:0] t;
        c = c_in;
        s = (step == '0) ? 8'd1 : step;
        // A color with all channels lit falls back to pure red.
        if (c.r != '0 && c.g != '0 && c.b != '0) begin
            c = PURE_RED;
        end
        if (c.g != FULL_SCALE && c.b == '0) begin
            // Red to green.
            d = {1'b0, c.r} - {1'b0, s};
            t = d[CHAN_W-1:0];
            if (d[CHAN_W]) begin
                c.r = '0;
                c.g = t;
                c.b = FULL_SCALE - t;
            end else begin
                c.r = t;
                c.g = c.g + s;
            end
        end else if (c.g != '0) begin
            // Green to blue.
            d = {1'b0, c.g} - {1'b0, s};
            t = d[CHAN_W-1:0];
            if (d[CHAN_W]) begin
                c.g = '0;
                c.b = t;
                c.r = FULL_SCALE - t;
            end else begin
                c.g = t;
                c.b = c.b + s;
            end
        end else begin
            // Blue to red.
            d = {1'b0, c.b} - {1'b0, s};
            t = d[CHAN_W-1:0];
            if (d[CHAN_W]) begin
                c.b = '0;
                c.r = t;
                c.g = FULL_SCALE - t;
            end else begin
                c.b = t;
                c.r = c.r + s;
            end
        end
        return c;
    endfunction

    // Rounded c * level / 255. The division by 255 uses
    // (p + (p >> 8) + 1) >> 8, which is exact for every p that can arise here.
    function automatic logic [CHAN_W-1:0] scale_channel(logic [CHAN_W-1:0] c,
                                                        logic [CHAN_W-1:0] level);
        logic [2*CHAN_W-1:0] p;
        logic [2*CHAN_W:0]   q;
        p = c * level + 16'd127;
        q = {1'b0, p} + {9'd0, p[2*CHAN_W-1:CHAN_W]} + 17'd1;
        return (level == FULL_SCALE) ? c : q[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

`default_nettype wire

// ----- design/rainbow_pixel_generator.sv -----
// An accepted s_ request moves through the input stage and output register to m_.
// Throughput: one pixel per clock cycle unless m_tready stalls the output; the
// input stage and the output register hold up to two pixels, and once both are
// full s_tready follows m_tready.
// Reset: synchronous, active low on aresetn; registers return to fade_step 1,
// brightness 255, rotate_mode 1, and both colors to pure red.
`default_nettype none

module rainbow_pixel_generator (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration write port.
    input  wire logic                         cfg_we,
    input  wire logic [rpg_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [rpg_pkg::CHAN_W-1:0]   cfg_wdata,
    // Request stream.
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [rpg_pkg::IN_W-1:0]     s_tdata,  // [0] new_frame, [7:1] zero
    // Pixel stream.
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rpg_pkg::OUT_W-1:0]         m_tdata   // [7:0] red, [15:8] green,
                                                        // [23:16] blue
);
    import rpg_pkg::*;

    cfg_t   cfg_reg;
    color_t px;
    logic   accept;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade_step   <= 8'd1;
            cfg_reg.brightness  <= FULL_SCALE;
            cfg_reg.rotate_mode <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FADE_STEP:   cfg_reg.fade_step   <= cfg_wdata;
                REG_BRIGHTNESS:  cfg_reg.brightness  <= cfg_wdata;
                REG_ROTATE_MODE: cfg_reg.rotate_mode <= cfg_wdata[0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign accept = s_tvalid && s_tready;

    rpg_color_state u_state (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .new_frame (s_tdata[0]),
        .cfg       (cfg_reg),
        .px        (px)
    );

    rpg_scaler u_scaler (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .px_valid   (s_tvalid),
        .px_ready   (s_tready),
        .px         (px),
        .brightness (cfg_reg.brightness),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

`default_nettype wire

// ----- design/rpg_color_state.sv -----
`default_nettype none

module rpg_color_state (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            accept,
    input  wire logic            new_frame,
    input  wire rpg_pkg::cfg_t   cfg,
    output rpg_pkg::color_t      px
);
    import rpg_pkg::*;

    color_t base_reg, base_next;
    color_t run_reg,  run_next;
    color_t base_faded;
    color_t run_cur;
    color_t run_faded;

    // A new frame advances the base color and reloads the running color.
    always_comb begin
        base_faded = fade_once(base_reg, cfg.fade_step);
        base_next  = new_frame ? base_faded : base_reg;
        run_cur    = new_frame ? base_faded : run_reg;
        run_faded  = fade_once(run_cur, cfg.fade_step);
        run_next   = cfg.rotate_mode ? run_faded : run_cur;
        px         = cfg.rotate_mode ? run_cur : base_next;
    end

    // State moves only when a transaction is accepted.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= PURE_RED;
            run_reg  <= PURE_RED;
        end else if (accept) begin
            base_reg <= base_next;
            run_reg  <= run_next;
        end
    end

`ifndef NO_ASSERTIONS
    // Every color on the wheel keeps one channel dark and sums to full scale.
    a_base_on_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_reg.r == '0 || base_reg.g == '0 || base_reg.b == '0) &&
        ({2'b0, base_reg.r} + {2'b0, base_reg.g} + {2'b0, base_reg.b} == 10'd255))
        else $error("base color left the wheel");

    a_run_on_wheel: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg.r == '0 || run_reg.g == '0 || run_reg.b == '0) &&
        ({2'b0, run_reg.r} + {2'b0, run_reg.g} + {2'b0, run_reg.b} == 10'd255))
        else $error("running color left the wheel");
`endif

endmodule

`default_nettype wire

// ----- design/rpg_scaler.sv -----
`default_nettype none

module rpg_scaler (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         px_valid,
    output logic                              px_ready,
    input  wire rpg_pkg::color_t              px,
    input  wire logic [rpg_pkg::CHAN_W-1:0]   brightness,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [rpg_pkg::OUT_W-1:0]         m_tdata
);
    import rpg_pkg::*;

    logic   stage_valid_reg;
    color_t stage_color_reg;
    logic   out_valid_reg;
    color_t out_color_reg, out_color_next;
    logic   out_advance;

    // The output register loads when it is empty or being drained.
    assign out_advance = !out_valid_reg || m_tready;
    assign px_ready    = !stage_valid_reg || out_advance;

    always_comb begin
        out_color_next.r = scale_channel(stage_color_reg.r, brightness);
        out_color_next.g = scale_channel(stage_color_reg.g, brightness);
        out_color_next.b = scale_channel(stage_color_reg.b, brightness);
    end

    // Valid bits of the input stage and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (px_ready) begin
                stage_valid_reg <= px_valid;
            end
            if (out_advance) begin
                out_valid_reg <= stage_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (px_ready && px_valid) begin
            stage_color_reg <= px;
        end
        if (out_advance && stage_valid_reg) begin
            out_color_reg <= out_color_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_color_reg;

`ifndef NO_ASSERTIONS
    // A pixel held in the input stage while the output stalls stays put.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid_reg && !out_advance |=> stage_valid_reg && $stable(stage_color_reg))
        else $error("stalled pixel lost in the input stage");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> px_ready)
        else $error("input blocked with an empty output register");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 3000;
    // Index past the last register; writes there must be ignored.
    localparam logic [rpg_pkg::IDX_W-1:0] UNUSED_REG = 2'd3;
    localparam int LONG_HOLD = 200;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [rpg_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [rpg_pkg::CHAN_W-1:0]    cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [rpg_pkg::IN_W-1:0]      s_tdata   = '0;   // [0] new_frame, [7:1] zero
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [rpg_pkg::OUT_W-1:0]     m_tdata;          // [7:0] red, [15:8] green,
                                                     // [23:16] blue

    // Shadow of the register file and the color state.
    logic [7:0]       fade_q   = 8'd1;
    logic [7:0]       bright_q = 8'd255;
    logic             rotate_q = 1'b1;
    rpg_pkg::color_t  base_col = '{b: 8'd0, g: 8'd0, r: 8'd255};
    rpg_pkg::color_t  run_col  = '{b: 8'd0, g: 8'd0, r: 8'd255};

    rpg_pkg::color_t  expected_pixels[$];

    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;
    int hold_request    = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int error_count     = 0;
    int requests_sent   = 0;
    int pixels_checked  = 0;

    rainbow_pixel_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One step around the color wheel. The active channel gives up the step to
    // the next one; when it runs out, what is left spills into the next pair.
    function automatic rpg_pkg::color_t wheel_advance(rpg_pkg::color_t c, logic [7:0] step);
        rpg_pkg::color_t n;
        logic [7:0]      s;
        logic [7:0]      rest;
        n = c;
        s = (step == 8'd0) ? 8'd1 : step;
        if (n.r != 8'd0 && n.g != 8'd0 && n.b != 8'd0) begin
            n = '{b: 8'd0, g: 8'd0, r: rpg_pkg::FULL_SCALE};
        end
        if (n.g != rpg_pkg::FULL_SCALE && n.b == 8'd0) begin
            rest = n.r - s;
            if (s > n.r) begin
                n.r = 8'd0;
                n.g = rest;
                n.b = rpg_pkg::FULL_SCALE - rest;
            end else begin
                n.r = rest;
                n.g = n.g + s;
            end
        end else if (n.g != 8'd0) begin
            rest = n.g - s;
            if (s > n.g) begin
                n.g = 8'd0;
                n.b = rest;
                n.r = rpg_pkg::FULL_SCALE - rest;
            end else begin
                n.g = rest;
                n.b = n.b + s;
            end
        end else begin
            rest = n.b - s;
            if (s > n.b) begin
                n.b = 8'd0;
                n.r = rest;
                n.g = rpg_pkg::FULL_SCALE - rest;
            end else begin
                n.b = rest;
                n.r = n.r + s;
            end
        end
        return n;
    endfunction

    // Brightness scaling, rounded to nearest; full scale passes through.
    function automatic logic [7:0] dim_channel(logic [7:0] c, logic [7:0] level);
        int unsigned prod;
        if (level == rpg_pkg::FULL_SCALE) begin
            return c;
        end
        prod = int'(level) * int'(c) + 127;
        return 8'(prod / 255);
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        error_count++;
        if (error_count <= 40) begin
            $display("MISMATCH %s at %0t ns: got %0d, expected %0d", what, $time, got_v,
                     want_v);
        end
    endtask

    // Register write; only called while no pixel is in flight.
    task automatic write_reg(logic [rpg_pkg::IDX_W-1:0] idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rpg_pkg::REG_FADE_STEP:   fade_q   = value;
            rpg_pkg::REG_BRIGHTNESS:  bright_q = value;
            rpg_pkg::REG_ROTATE_MODE: rotate_q = value[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic apply_settings(logic [7:0] step, logic [7:0] level, logic rot);
        write_reg(rpg_pkg::REG_FADE_STEP, step);
        write_reg(rpg_pkg::REG_BRIGHTNESS, level);
        write_reg(rpg_pkg::REG_ROTATE_MODE, {7'd0, rot});
    endtask

    // Offer one pixel request, with a random gap before it, and predict the
    // pixel once the transaction is accepted.
    task automatic send_request(logic new_frame);
        rpg_pkg::color_t px;
        rpg_pkg::color_t want;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, new_frame};
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (new_frame) begin
            base_col = wheel_advance(base_col, fade_q);
            run_col  = base_col;
        end
        if (rotate_q) begin
            px      = run_col;
            run_col = wheel_advance(run_col, fade_q);
        end else begin
            px = base_col;
        end
        want.r = dim_channel(px.r, bright_q);
        want.g = dim_channel(px.g, bright_q);
        want.b = dim_channel(px.b, bright_q);
        expected_pixels.push_back(want);
    endtask

    // Stop offering requests and wait until every predicted pixel has arrived.
    task automatic wait_for_pixels();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_pixels.size() != 0);
    endtask

    // Pixel sink: random stalls, plus a long hold when one is requested.
    always @(posedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Compare each accepted pixel with the oldest prediction.
    always @(posedge aclk) begin : check_pixels
        rpg_pkg::color_t got;
        rpg_pkg::color_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected pixel (red)", got.r, 0);
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.r != want.r) report_mismatch("red", got.r, want.r);
                if (got.g != want.g) report_mismatch("green", got.g, want.g);
                if (got.b != want.b) report_mismatch("blue", got.b, want.b);
            end
        end
    end

    // Hang detection: no transaction on either stream for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Pixels before the first frame, then a frame start, at reset settings.
    task automatic test_power_up_state();
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_pixels();
    endtask

    // A zero step behaves as one; the largest step wraps every channel pair.
    task automatic test_fade_steps();
        write_reg(rpg_pkg::REG_FADE_STEP, 8'd0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_FADE_STEP, 8'd255);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_FADE_STEP, 8'd128);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        wait_for_pixels();
    endtask

    // Brightness at both ends and just inside them.
    task automatic test_brightness();
        write_reg(rpg_pkg::REG_FADE_STEP, 8'd37);
        write_reg(rpg_pkg::REG_BRIGHTNESS, 8'd0);
        send_request(1'b1);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_BRIGHTNESS, 8'd1);
        send_request(1'b0);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_BRIGHTNESS, 8'd127);
        send_request(1'b0);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_BRIGHTNESS, 8'd254);
        send_request(1'b1);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_BRIGHTNESS, 8'd255);
        send_request(1'b0);
        wait_for_pixels();
    endtask

    // Uniform mode, selected through a value with upper bits set; a write to
    // the unused index must change nothing.
    task automatic test_uniform_mode();
        write_reg(rpg_pkg::REG_ROTATE_MODE, 8'hFE);
        write_reg(UNUSED_REG, 8'hFF);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        wait_for_pixels();
        write_reg(rpg_pkg::REG_ROTATE_MODE, 8'h03);
        send_request(1'b0);
        wait_for_pixels();
    endtask

    // Random frames under one traffic profile, reconfigured between bursts.
    task automatic test_random_frames(int src_pct, int snk_pct, int bursts);
        logic [7:0] step;
        logic [7:0] level;
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        for (int k = 0; k < bursts; k++) begin
            case ($urandom_range(0, 5))
                0:       step = 8'd0;
                1:       step = 8'd255;
                2:       step = 8'd1;
                default: step = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       level = 8'd255;
                1:       level = 8'd0;
                default: level = 8'($urandom_range(0, 255));
            endcase
            apply_settings(step, level, $urandom_range(0, 3) != 0);
            for (int i = 0; i < 35; i++) begin
                send_request($urandom_range(0, 7) == 0);
            end
            wait_for_pixels();
        end
    endtask

    // Hold the sink long enough that the block fills and stalls its input,
    // then let everything drain before sending more.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        apply_settings(8'd9, 8'd200, 1'b1);
        hold_request = LONG_HOLD;
        for (int i = 0; i < 24; i++) begin
            send_request(i % 6 == 0);
        end
        wait_for_pixels();
        src_idle_pct = 50;
        for (int i = 0; i < 6; i++) begin
            send_request(i == 0);
        end
        wait_for_pixels();
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        test_power_up_state();
        test_fade_steps();
        test_brightness();
        test_uniform_mode();
        test_random_frames(0, 0, 4);
        test_random_frames(86, 0, 4);
        test_random_frames(0, 86, 4);
        test_random_frames(10, 10, 4);
        test_backpressure();

        wait_for_pixels();
        repeat (4) @(posedge aclk);

        $display("Checked %0d pixels from %0d requests across fade steps, brightness levels",
                 pixels_checked, requests_sent);
        $display("and both color modes, under free, gapped, stalled and held-off traffic.");
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
